// ----- src/bqbt_pkg.sv -----
`timescale 1ns / 1ps
package bqbt_pkg;

  // Width of each signed bracket depth counter
  localparam int unsigned DEPTH_BITS = 8;

  localparam logic signed [DEPTH_BITS-1:0] DEPTH_MAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
  localparam logic signed [DEPTH_BITS-1:0] DEPTH_MIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};

  // Character codes
  localparam logic [7:0] CHR_BSLASH = 8'h5C;
  localparam logic [7:0] CHR_SQUOTE = 8'h27;
  localparam logic [7:0] CHR_DQUOTE = 8'h22;
  localparam logic [7:0] CHR_LPAREN = 8'h28;
  localparam logic [7:0] CHR_RPAREN = 8'h29;
  localparam logic [7:0] CHR_LSQ    = 8'h5B;
  localparam logic [7:0] CHR_RSQ    = 8'h5D;
  localparam logic [7:0] CHR_LCURLY = 8'h7B;
  localparam logic [7:0] CHR_RCURLY = 8'h7D;
  localparam logic [7:0] CHR_SEMI   = 8'h3B;
  localparam logic [7:0] CHR_NL     = 8'h0A;
  localparam logic [7:0] CHR_TAB    = 8'h09;
  localparam logic [7:0] CHR_SPACE  = 8'h20;

  // Quote mode codes
  localparam logic [1:0] QM_NONE   = 2'd0;
  localparam logic [1:0] QM_SINGLE = 2'd1;
  localparam logic [1:0] QM_DOUBLE = 2'd2;

  // Byte classes decided by the front end
  typedef enum logic [3:0] {
    CLS_OTHER,
    CLS_BSLASH,
    CLS_SQUOTE,
    CLS_DQUOTE,
    CLS_LPAREN,
    CLS_RPAREN,
    CLS_LSQ,
    CLS_RSQ,
    CLS_LCURLY,
    CLS_RCURLY,
    CLS_SEMI,
    CLS_BLANK
  } cls_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       start_of_text;
  } in_word_t;

  typedef struct packed {
    logic       brackets_balanced;
    logic       statement_closed;
    logic [1:0] quote_mode;
    logic       depth_saturated;
  } out_word_t;

  // Classified word passed from front to back
  typedef struct packed {
    cls_e cls;
    logic start;
  } cmd_t;

endpackage

// ----- src/bqbt_front.sv -----
`timescale 1ns / 1ps
module bqbt_front (
  input  logic               in_valid_i,
  input  bqbt_pkg::in_word_t in_word_i,
  output logic               in_stall_o,
  input  logic               q_full_i,
  output logic               push_o,
  output bqbt_pkg::cmd_t     cmd_o
);
  import bqbt_pkg::*;

  cls_e cls;

  // Map each byte to its class
  always_comb begin
    case (in_word_i.text_byte) inside
      CHR_BSLASH:                   cls = CLS_BSLASH;
      CHR_SQUOTE:                   cls = CLS_SQUOTE;
      CHR_DQUOTE:                   cls = CLS_DQUOTE;
      CHR_LPAREN:                   cls = CLS_LPAREN;
      CHR_RPAREN:                   cls = CLS_RPAREN;
      CHR_LSQ:                      cls = CLS_LSQ;
      CHR_RSQ:                      cls = CLS_RSQ;
      CHR_LCURLY:                   cls = CLS_LCURLY;
      CHR_RCURLY:                   cls = CLS_RCURLY;
      CHR_SEMI:                     cls = CLS_SEMI;
      CHR_SPACE, CHR_NL, CHR_TAB:   cls = CLS_BLANK;
      default:                      cls = CLS_OTHER;
    endcase
  end

  assign in_stall_o  = q_full_i;
  assign push_o      = in_valid_i && !q_full_i;
  assign cmd_o.cls   = cls;
  assign cmd_o.start = in_word_i.start_of_text;

endmodule

// ----- src/bqbt_queue.sv -----
`timescale 1ns / 1ps
module bqbt_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bqbt_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output bqbt_pkg::cmd_t cmd_o
);
  import bqbt_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    count_d  = count_q + {1'b0, push_i} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ----- src/bqbt_exec.sv -----
`timescale 1ns / 1ps
module bqbt_exec (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  bqbt_pkg::cmd_t      cmd_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bqbt_pkg::out_word_t out_word_o
);
  import bqbt_pkg::*;

  typedef logic signed [DEPTH_BITS-1:0] depth_t;

  logic      sq_q, sq_d;
  logic      dq_q, dq_d;
  logic      esc_q, esc_d;
  depth_t    paren_q, paren_d;
  depth_t    square_q, square_d;
  depth_t    curly_q, curly_d;
  logic      tail_q, tail_d;
  logic      brace_q, brace_d;
  logic      out_valid_q;
  out_word_t out_q, out_d;

  logic   sq, dq, esc, tail, brace;
  depth_t paren, square, curly;
  logic   balanced;

  // Saturating step of one depth counter
  function automatic depth_t bump(depth_t d, logic up);
    depth_t r;
    r = d;
    if (up) begin
      if (d != DEPTH_MAX) r = d + depth_t'(1);
    end else begin
      if (d != DEPTH_MIN) r = d - depth_t'(1);
    end
    return r;
  endfunction

  function automatic logic at_limit(depth_t d);
    return (d == DEPTH_MAX) || (d == DEPTH_MIN);
  endfunction

  // Take a word when the output register is free or being drained
  assign pop_o = q_valid_i && (!out_valid_q || !out_stall_i);

  // Start of text clears state before the byte is applied
  always_comb begin
    sq     = cmd_i.start ? 1'b0 : sq_q;
    dq     = cmd_i.start ? 1'b0 : dq_q;
    esc    = cmd_i.start ? 1'b0 : esc_q;
    paren  = cmd_i.start ? '0 : paren_q;
    square = cmd_i.start ? '0 : square_q;
    curly  = cmd_i.start ? '0 : curly_q;
    tail   = cmd_i.start ? 1'b0 : tail_q;
    brace  = cmd_i.start ? 1'b0 : brace_q;
  end

  // Quote and bracket pass
  always_comb begin
    sq_d     = sq;
    dq_d     = dq;
    esc_d    = esc;
    paren_d  = paren;
    square_d = square;
    curly_d  = curly;
    if (esc) begin
      esc_d = 1'b0;
    end else if (sq) begin
      if (cmd_i.cls == CLS_BSLASH) esc_d = 1'b1;
      else if (cmd_i.cls == CLS_SQUOTE) sq_d = 1'b0;
    end else if (dq) begin
      if (cmd_i.cls == CLS_BSLASH) esc_d = 1'b1;
      else if (cmd_i.cls == CLS_DQUOTE) dq_d = 1'b0;
    end else begin
      case (cmd_i.cls)
        CLS_SQUOTE: sq_d     = 1'b1;
        CLS_DQUOTE: dq_d     = 1'b1;
        CLS_LPAREN: paren_d  = bump(paren, 1'b1);
        CLS_RPAREN: paren_d  = bump(paren, 1'b0);
        CLS_LSQ:    square_d = bump(square, 1'b1);
        CLS_RSQ:    square_d = bump(square, 1'b0);
        CLS_LCURLY: curly_d  = bump(curly, 1'b1);
        CLS_RCURLY: curly_d  = bump(curly, 1'b0);
        default:    ;
      endcase
    end
  end

  // Statement-end pass, ignores quotes
  always_comb begin
    tail_d  = tail;
    brace_d = brace;
    if (tail) begin
      if (cmd_i.cls != CLS_BLANK) tail_d = 1'b0;
    end else if (cmd_i.cls == CLS_RCURLY) begin
      brace_d = 1'b1;
    end else if (cmd_i.cls == CLS_SEMI) begin
      tail_d = 1'b1;
    end
  end

  // Result word from the updated state
  always_comb begin
    balanced                = (paren_d == '0) && (square_d == '0) && (curly_d == '0);
    out_d.brackets_balanced = balanced;
    out_d.statement_closed  = balanced && (tail_d || brace_d);
    out_d.quote_mode        = sq_d ? QM_SINGLE : (dq_d ? QM_DOUBLE : QM_NONE);
    out_d.depth_saturated   = at_limit(paren_d) || at_limit(square_d) || at_limit(curly_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_q        <= 1'b0;
      dq_q        <= 1'b0;
      esc_q       <= 1'b0;
      paren_q     <= '0;
      square_q    <= '0;
      curly_q     <= '0;
      tail_q      <= 1'b0;
      brace_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        sq_q     <= sq_d;
        dq_q     <= dq_d;
        esc_q    <= esc_d;
        paren_q  <= paren_d;
        square_q <= square_d;
        curly_q  <= curly_d;
        tail_q   <= tail_d;
        brace_q  <= brace_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// ----- src/bracket_quote_balance_tracker_core.sv -----
// Flow: a word accepted into the queue is popped into the output register when that register
// is free or being drained, and its result is then taken from the output register.
// Throughput: one word per cycle while neither side stalls; the two-entry queue between
// classifier and state update lets input and output stall independently.
// Reset: rst_ni is asynchronous, active low; it clears all tracking state, the queue and
// the output valid. start_of_text clears tracking state ahead of its own byte.
`timescale 1ns / 1ps
module bracket_quote_balance_tracker_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bqbt_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bqbt_pkg::out_word_t out_word_o
);
  import bqbt_pkg::*;

  logic q_full;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic q_valid;
  cmd_t pop_cmd;

  // Front: accept and classify
  bqbt_front u_front (
    .in_valid_i (in_valid_i),
    .in_word_i  (in_word_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  // Decoupling queue
  bqbt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (pop_cmd)
  );

  // Back: state update and result register
  bqbt_exec u_exec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .cmd_i       (pop_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import bqbt_pkg::*;

  // Cycles without any accepted input word or taken result before the run is declared hung
  localparam int IDLE_LIMIT = 1000;
  localparam int RANDOM_WORDS = 1800;

  logic      clk_i;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  bracket_quote_balance_tracker_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word)
  );

  // Pending text bytes and the balance results they should produce
  in_word_t  text_q[$];
  out_word_t balance_expected_q[$];
  int        mismatch_cnt = 0;
  int        result_idx = 0;

  // Shadow tracking state
  logic                         sq_open = 1'b0;
  logic                         dq_open = 1'b0;
  logic                         esc_pending = 1'b0;
  logic signed [DEPTH_BITS-1:0] paren_lvl = '0;
  logic signed [DEPTH_BITS-1:0] square_lvl = '0;
  logic signed [DEPTH_BITS-1:0] curly_lvl = '0;
  logic                         semi_tail = 1'b0;
  logic                         brace_hit = 1'b0;

  // Flow control state for both sides
  int gap_left = 0;
  int stall_left = 0;
  bit quiet_tx = 1'b0;
  bit quiet_rx = 1'b0;
  int idle_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Saturating step of one signed depth counter
  function automatic logic signed [DEPTH_BITS-1:0] step_depth(
      logic signed [DEPTH_BITS-1:0] d, bit up);
    if (up) return (d == DEPTH_MAX) ? d : d + DEPTH_BITS'(1);
    return (d == DEPTH_MIN) ? d : d - DEPTH_BITS'(1);
  endfunction

  function automatic bit at_limit(logic signed [DEPTH_BITS-1:0] d);
    return (d == DEPTH_MAX) || (d == DEPTH_MIN);
  endfunction

  // Advance the shadow state by one byte and return the expected status word
  function automatic out_word_t track_byte(in_word_t w);
    out_word_t  r;
    logic [7:0] c;
    logic       bal;
    c = w.text_byte;
    if (w.start_of_text) begin
      sq_open     = 1'b0;
      dq_open     = 1'b0;
      esc_pending = 1'b0;
      paren_lvl   = '0;
      square_lvl  = '0;
      curly_lvl   = '0;
      semi_tail   = 1'b0;
      brace_hit   = 1'b0;
    end

    // quote pass; brackets only count outside strings
    if (esc_pending) begin
      esc_pending = 1'b0;
    end else if (sq_open) begin
      if (c == CHR_BSLASH) esc_pending = 1'b1;
      else if (c == CHR_SQUOTE) sq_open = 1'b0;
    end else if (dq_open) begin
      if (c == CHR_BSLASH) esc_pending = 1'b1;
      else if (c == CHR_DQUOTE) dq_open = 1'b0;
    end else begin
      case (c)
        CHR_SQUOTE: sq_open = 1'b1;
        CHR_DQUOTE: dq_open = 1'b1;
        CHR_LPAREN: paren_lvl = step_depth(paren_lvl, 1'b1);
        CHR_RPAREN: paren_lvl = step_depth(paren_lvl, 1'b0);
        CHR_LSQ:    square_lvl = step_depth(square_lvl, 1'b1);
        CHR_RSQ:    square_lvl = step_depth(square_lvl, 1'b0);
        CHR_LCURLY: curly_lvl = step_depth(curly_lvl, 1'b1);
        CHR_RCURLY: curly_lvl = step_depth(curly_lvl, 1'b0);
        default: ;
      endcase
    end

    // statement-end pass ignores quotes
    if (semi_tail) begin
      if (c != CHR_SPACE && c != CHR_NL && c != CHR_TAB) semi_tail = 1'b0;
    end else if (c == CHR_RCURLY) begin
      brace_hit = 1'b1;
    end else if (c == CHR_SEMI) begin
      semi_tail = 1'b1;
    end

    bal = (paren_lvl == '0) && (square_lvl == '0) && (curly_lvl == '0);
    r.brackets_balanced = bal;
    r.statement_closed  = bal && (semi_tail || brace_hit);
    r.quote_mode        = sq_open ? QM_SINGLE : (dq_open ? QM_DOUBLE : QM_NONE);
    r.depth_saturated   = at_limit(paren_lvl) || at_limit(square_lvl) ||
                          at_limit(curly_lvl);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH result %0d %s: got %0d expected %0d", result_idx, what, got, want);
    mismatch_cnt++;
  endtask

  // Text generation helpers
  task automatic push_byte(input logic [7:0] b, input bit sot);
    in_word_t w;
    w.text_byte     = b;
    w.start_of_text = sot;
    text_q.push_back(w);
  endtask

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 2))
      0:       return CHR_SPACE;
      1:       return CHR_NL;
      default: return CHR_TAB;
    endcase
  endfunction

  function automatic logic [7:0] pick_filler();
    case ($urandom_range(0, 4))
      0:       return pick_blank();
      1:       return "0" + 8'($urandom_range(0, 9));
      default: return "a" + 8'($urandom_range(0, 25));
    endcase
  endfunction

  function automatic logic [7:0] pick_special();
    case ($urandom_range(0, 6))
      0:       return CHR_LPAREN;
      1:       return CHR_RPAREN;
      2:       return CHR_LSQ;
      3:       return CHR_RSQ;
      4:       return CHR_LCURLY;
      5:       return CHR_RCURLY;
      default: return CHR_SEMI;
    endcase
  endfunction

  task automatic pick_pair(output logic [7:0] op, output logic [7:0] cl);
    case ($urandom_range(0, 2))
      0:       begin op = CHR_LPAREN; cl = CHR_RPAREN; end
      1:       begin op = CHR_LSQ;    cl = CHR_RSQ;    end
      default: begin op = CHR_LCURLY; cl = CHR_RCURLY; end
    endcase
  endtask

  // Quoted string with random escapes and bracket noise inside
  task automatic push_string();
    logic [7:0] q;
    q = $urandom_range(0, 1) ? CHR_SQUOTE : CHR_DQUOTE;
    push_byte(q, 1'b0);
    repeat ($urandom_range(0, 6)) begin
      case ($urandom_range(0, 5))
        0: begin
          push_byte(CHR_BSLASH, 1'b0);
          push_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        1:       push_byte(pick_special(), 1'b0);
        2:       push_byte((q == CHR_SQUOTE) ? CHR_DQUOTE : CHR_SQUOTE, 1'b0);
        default: push_byte(pick_filler(), 1'b0);
      endcase
    end
    push_byte(q, 1'b0);
  endtask

  // Well-formed statement: nested brackets, strings, ends in ';' or a block
  task automatic push_statement();
    logic [7:0] closers[$];
    logic [7:0] op, cl;
    push_byte(pick_filler(), $urandom_range(0, 3) != 0);
    repeat ($urandom_range(3, 20)) begin
      case ($urandom_range(0, 7))
        0, 1: begin
          pick_pair(op, cl);
          push_byte(op, 1'b0);
          closers.push_back(cl);
        end
        2:       if (closers.size() != 0) push_byte(closers.pop_back(), 1'b0);
        3:       push_string();
        4:       begin push_byte(CHR_SEMI, 1'b0); push_byte(pick_blank(), 1'b0); end
        default: push_byte(pick_filler(), 1'b0);
      endcase
    end
    while (closers.size() != 0) push_byte(closers.pop_back(), 1'b0);
    if ($urandom_range(0, 1)) begin
      push_byte(CHR_SEMI, 1'b0);
    end else begin
      push_byte(CHR_LCURLY, 1'b0);
      push_byte(pick_filler(), 1'b0);
      push_byte(CHR_RCURLY, 1'b0);
    end
    repeat ($urandom_range(0, 3)) push_byte(pick_blank(), 1'b0);
  endtask

  // Long run of one bracket kind to drive a counter into saturation
  task automatic push_burst(input bit up);
    logic [7:0] op, cl;
    pick_pair(op, cl);
    push_byte(up ? op : cl, 1'b1);
    repeat ($urandom_range(128, 140)) push_byte(up ? op : cl, 1'b0);
    repeat ($urandom_range(1, 3)) push_byte(up ? cl : op, 1'b0);
  endtask

  // Unstructured bytes, all values
  task automatic push_noise();
    repeat ($urandom_range(1, 10))
      push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
  endtask

  // Tokens that matter, in random and mostly broken order
  task automatic push_broken();
    push_byte(pick_special(), $urandom_range(0, 1) != 0);
    repeat ($urandom_range(1, 14)) begin
      case ($urandom_range(0, 4))
        0:       push_byte(pick_special(), 1'b0);
        1:       push_byte($urandom_range(0, 1) ? CHR_SQUOTE : CHR_DQUOTE, 1'b0);
        2:       push_byte(CHR_BSLASH, 1'b0);
        3:       push_byte(pick_blank(), 1'b0);
        default: push_byte(pick_filler(), 1'b0);
      endcase
    end
  endtask

  // Driver: presents queued words, holds them while stalled
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        balance_expected_q.push_back(track_byte(in_word));
        gap_left = quiet_tx ? 0 : $urandom_range(0, 16);
        if ($urandom_range(0, 49) == 0) quiet_tx = !quiet_tx;
      end
      if (in_valid && in_stall) begin
        // hold the word
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (text_q.size() != 0) begin
        in_word  <= text_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each result word against the oldest expectation
  always @(posedge clk_i) begin : mon
    out_word_t want;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (balance_expected_q.size() == 0) begin
          report_mismatch("unexpected word", int'(out_word), 0);
        end else begin
          want = balance_expected_q.pop_front();
          if (out_word.brackets_balanced !== want.brackets_balanced)
            report_mismatch("brackets_balanced", int'(out_word.brackets_balanced),
                            int'(want.brackets_balanced));
          if (out_word.statement_closed !== want.statement_closed)
            report_mismatch("statement_closed", int'(out_word.statement_closed),
                            int'(want.statement_closed));
          if (out_word.quote_mode !== want.quote_mode)
            report_mismatch("quote_mode", int'(out_word.quote_mode),
                            int'(want.quote_mode));
          if (out_word.depth_saturated !== want.depth_saturated)
            report_mismatch("depth_saturated", int'(out_word.depth_saturated),
                            int'(want.depth_saturated));
        end
        result_idx++;
        stall_left = quiet_rx ? 0 : $urandom_range(0, 16);
        if ($urandom_range(0, 49) == 0) quiet_rx = !quiet_rx;
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  // Watchdog on handshake progress
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("Mismatches found");
          $finish;
        end
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int directed_n;
    int seq;
    int r;

    // directed: counters, statement-end rules, quotes and escapes
    push_byte(CHR_LPAREN, 1'b1);
    push_byte(CHR_RPAREN, 1'b0);   // balanced, not yet closed
    push_byte(CHR_SEMI, 1'b0);     // closed by semicolon
    push_byte(CHR_SPACE, 1'b0);    // blanks keep the tail
    push_byte(CHR_TAB, 1'b0);
    push_byte(CHR_NL, 1'b0);
    push_byte(CHR_SEMI, 1'b0);     // second semicolon drops the tail
    push_byte(CHR_RCURLY, 1'b0);   // brace seen, curly goes negative
    push_byte(CHR_LCURLY, 1'b0);   // back to balanced, closed by brace
    push_byte(CHR_LSQ, 1'b0);
    push_byte(CHR_RSQ, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(CHR_SQUOTE, 1'b0);
    push_byte(CHR_LPAREN, 1'b0);   // ignored inside the string
    push_byte(CHR_BSLASH, 1'b0);
    push_byte(CHR_SQUOTE, 1'b0);   // escaped quote stays in the string
    push_byte(CHR_SEMI, 1'b0);     // tail set even inside quotes
    push_byte(CHR_SQUOTE, 1'b0);
    push_byte(CHR_DQUOTE, 1'b0);
    push_byte(CHR_SQUOTE, 1'b0);   // other quote kind has no effect
    push_byte(CHR_BSLASH, 1'b0);
    push_byte(CHR_BSLASH, 1'b0);   // escaped backslash
    push_byte(CHR_DQUOTE, 1'b0);
    push_byte(CHR_SEMI, 1'b1);
    push_byte(CHR_RCURLY, 1'b0);   // clears tail without marking a brace
    directed_n = text_q.size();

    // random: saturating bursts, mostly well-formed statements, some noise and broken text
    seq = 0;
    while (text_q.size() < directed_n + RANDOM_WORDS) begin
      r = $urandom_range(0, 39);
      if (seq < 2) push_burst(seq == 0);
      else if (r == 0) push_burst($urandom_range(0, 1) != 0);
      else if (r <= 4) push_noise();
      else if (r <= 8) push_broken();
      else push_statement();
      seq++;
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(negedge clk_i);
    while (text_q.size() != 0 || in_valid || balance_expected_q.size() != 0)
      @(negedge clk_i);
    repeat (8) @(negedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
